### hw/rtl/gpioc_pkg.sv
package gpioc_pkg;

   // Item operation codes; the fourth code of the field does nothing
   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_SAMPLE = 2'd2
   } op_type;

   // Sequencer states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // Register group hit by a bus address
   typedef enum logic [2:0] {
      TGT_NONE  = 3'd0,
      TGT_OUT   = 3'd1,
      TGT_ENA   = 3'd2,
      TGT_STS   = 3'd3,
      TGT_INPUT = 3'd4,
      TGT_INT   = 3'd5,
      TGT_PIN   = 3'd6
   } target_type;

   // Access flavor inside a direct/set/clear group
   typedef enum logic [1:0] {
      KIND_DIRECT = 2'd0,
      KIND_SET    = 2'd1,
      KIND_CLEAR  = 2'd2
   } kind_type;

   typedef struct packed {
      target_type target;
      logic       hi;
      kind_type   kind;
   } decode_type;

   // Register word indexes (byte offset / 4)
   localparam logic [6:0] OUT_BASE_WORD   = 7'h01;  // 0x04
   localparam logic [6:0] ENA_BASE_WORD   = 7'h08;  // 0x20
   localparam logic [6:0] STS_BASE_WORD   = 7'h11;  // 0x44
   localparam logic [6:0] INPUT_LO_WORD   = 7'h0f;  // 0x3c
   localparam logic [6:0] INPUT_HI_WORD   = 7'h10;  // 0x40
   localparam logic [6:0] INT_LO_WORD_V0  = 7'h18;  // 0x60
   localparam logic [6:0] INT_HI_WORD_V0  = 7'h1d;  // 0x74
   localparam logic [6:0] INT_LO_WORD_V1  = 7'h17;  // 0x5c
   localparam logic [6:0] INT_HI_WORD_V1  = 7'h1a;  // 0x68
   localparam logic [6:0] PIN_BASE_WORD_V0 = 7'h22; // 0x88
   localparam logic [6:0] PIN_BASE_WORD_V1 = 7'h1d; // 0x74
   localparam logic [6:0] GROUP_WORDS     = 7'd6;

   // Pin count of the small variant
   localparam int SMALL_PINS = 40;

   // Pin word fields
   localparam int OD_POS      = 2;
   localparam int TYPE_LSB    = 7;
   localparam int EN_LO_POS   = 13;
   localparam int EN_HI_POS   = 15;

   // Interrupt types
   localparam logic [2:0] TYPE_RISE = 3'd1;
   localparam logic [2:0] TYPE_FALL = 3'd2;
   localparam logic [2:0] TYPE_ANY  = 3'd3;
   localparam logic [2:0] TYPE_LOW  = 3'd4;
   localparam logic [2:0] TYPE_HIGH = 3'd5;

endpackage

### hw/rtl/gpioc_ram.sv
module gpioc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 49
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/gpioc_decode.sv
module gpioc_decode #(
   parameter int MAX_PINS = 49
) (
   input  logic                        variant,
   input  logic [8:0]                  address,
   output gpioc_pkg::decode_type       dec,
   output logic [$clog2(MAX_PINS)-1:0] pin_idx
);

   localparam int IDX_W = $clog2(MAX_PINS);
   localparam int PC0   = (MAX_PINS < gpioc_pkg::SMALL_PINS) ? MAX_PINS
                                                            : gpioc_pkg::SMALL_PINS;

   logic [6:0] word;
   logic [6:0] off_out;
   logic [6:0] off_ena;
   logic [6:0] off_sts;
   logic [6:0] pin_start;
   logic [6:0] pin_off;
   logic [6:0] pin_cnt;
   logic [6:0] int_lo;
   logic [6:0] int_hi;
   logic       hit_out;
   logic       hit_ena;
   logic       hit_sts;
   logic       hit_pin;

   // Map a group word offset to its access flavor
   function automatic gpioc_pkg::kind_type kind_of(input logic [6:0] off);
      gpioc_pkg::kind_type k;
      case (off[2:0])
         3'd0, 3'd3: k = gpioc_pkg::KIND_DIRECT;
         3'd1, 3'd4: k = gpioc_pkg::KIND_SET;
         default:    k = gpioc_pkg::KIND_CLEAR;
      endcase
      return k;
   endfunction

   // Offsets and range checks
   always_comb begin
      word      = address[8:2];
      off_out   = word - gpioc_pkg::OUT_BASE_WORD;
      off_ena   = word - gpioc_pkg::ENA_BASE_WORD;
      off_sts   = word - gpioc_pkg::STS_BASE_WORD;
      hit_out   = (word >= gpioc_pkg::OUT_BASE_WORD) && (off_out < gpioc_pkg::GROUP_WORDS);
      hit_ena   = (word >= gpioc_pkg::ENA_BASE_WORD) && (off_ena < gpioc_pkg::GROUP_WORDS);
      hit_sts   = (word >= gpioc_pkg::STS_BASE_WORD) && (off_sts < gpioc_pkg::GROUP_WORDS);
      pin_start = variant ? gpioc_pkg::PIN_BASE_WORD_V1 : gpioc_pkg::PIN_BASE_WORD_V0;
      int_lo    = variant ? gpioc_pkg::INT_LO_WORD_V1 : gpioc_pkg::INT_LO_WORD_V0;
      int_hi    = variant ? gpioc_pkg::INT_HI_WORD_V1 : gpioc_pkg::INT_HI_WORD_V0;
      pin_cnt   = variant ? 7'(MAX_PINS) : 7'(PC0);
      pin_off   = word - pin_start;
      hit_pin   = (word >= pin_start) && (pin_off < pin_cnt);
      pin_idx   = pin_off[IDX_W-1:0];
   end

   // Pick the first group that claims the address
   always_comb begin
      dec.target = gpioc_pkg::TGT_NONE;
      dec.hi     = 1'b0;
      dec.kind   = gpioc_pkg::KIND_DIRECT;
      priority if (hit_out) begin
         dec.target = gpioc_pkg::TGT_OUT;
         dec.hi     = (off_out >= 7'd3);
         dec.kind   = kind_of(off_out);
      end else if (hit_ena) begin
         dec.target = gpioc_pkg::TGT_ENA;
         dec.hi     = (off_ena >= 7'd3);
         dec.kind   = kind_of(off_ena);
      end else if (hit_sts) begin
         dec.target = gpioc_pkg::TGT_STS;
         dec.hi     = (off_sts >= 7'd3);
         dec.kind   = kind_of(off_sts);
      end else if ((word == gpioc_pkg::INPUT_LO_WORD) || (word == gpioc_pkg::INPUT_HI_WORD)) begin
         dec.target = gpioc_pkg::TGT_INPUT;
         dec.hi     = (word == gpioc_pkg::INPUT_HI_WORD);
      end else if ((word == int_lo) || (word == int_hi)) begin
         dec.target = gpioc_pkg::TGT_INT;
         dec.hi     = (word == int_hi);
      end else if (hit_pin) begin
         dec.target = gpioc_pkg::TGT_PIN;
      end else begin
         dec.target = gpioc_pkg::TGT_NONE;
      end
   end

endmodule

### hw/rtl/gpio_controller_with_pin_interrupts_core.sv
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+-------------------------------
// request   | req_operation/address/write_data/       | start && !busy
//           | pin_levels                              |
// response  | rsp_read_data/irq/bad_address/          | rsp_valid, one cycle, no stall
//           | drive_value/drive_enable/open_drain     |
// csr       | csr_chip_variant                        | csr_valid && csr_ready
//
// Each item reads the pin word memory at accept, then modifies state and writes back
// in the execute state; the registered read port of the pin word memory sets this order.
// The result strobes in the cycle after execute, while the next item may be accepted.
// Reset clears all pin state; pin words not yet written read as zero via valid bits.
// The result cannot be stalled; csr writes are taken only between items.
module gpio_controller_with_pin_interrupts_core #(
   parameter int MAX_PINS = 49
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_operation,
   input  logic [8:0]          req_address,
   input  logic [31:0]         req_write_data,
   input  logic [MAX_PINS-1:0] req_pin_levels,
   output logic                rsp_valid,
   output logic [31:0]         rsp_read_data,
   output logic                rsp_irq,
   output logic                rsp_bad_address,
   output logic [MAX_PINS-1:0] rsp_drive_value,
   output logic [MAX_PINS-1:0] rsp_drive_enable,
   output logic [MAX_PINS-1:0] rsp_open_drain,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_chip_variant
);

   localparam int IDX_W = $clog2(MAX_PINS);
   localparam int PC0   = (MAX_PINS < gpioc_pkg::SMALL_PINS) ? MAX_PINS
                                                            : gpioc_pkg::SMALL_PINS;
   localparam logic [MAX_PINS-1:0] ACT0 = MAX_PINS'((65'd1 << PC0) - 65'd1);

   gpioc_pkg::state_type  state_ff, state_in;
   logic                  accept;
   logic                  variant_ff;

   // Latched item
   gpioc_pkg::op_type     op_ff;
   logic [31:0]           wdata_ff;
   logic [MAX_PINS-1:0]   levels_ff;
   gpioc_pkg::decode_type dec_ff;
   logic [IDX_W-1:0]      idx_ff;
   gpioc_pkg::decode_type dec;
   logic [IDX_W-1:0]      pin_idx;

   // Pin state
   logic [MAX_PINS-1:0]   out_ff, out_in;
   logic [MAX_PINS-1:0]   ena_ff, ena_in;
   logic [MAX_PINS-1:0]   sts_ff, sts_in;
   logic [MAX_PINS-1:0]   last_ff, last_in;
   logic [MAX_PINS-1:0]   od_ff, od_in;
   logic [MAX_PINS-1:0]   en_lo_ff, en_lo_in;
   logic [MAX_PINS-1:0]   en_hi_ff, en_hi_in;
   logic [MAX_PINS-1:0]   valid_ff, valid_in;
   logic [2:0]            type_ff [MAX_PINS];
   logic [2:0]            type_in [MAX_PINS];

   // Pin word memory
   logic                  ram_we;
   logic [31:0]           ram_rdata;

   // Result registers
   logic                  rsp_valid_ff;
   logic [31:0]           rsp_read_data_ff, rsp_read_data_in;
   logic                  rsp_irq_ff, rsp_irq_in;
   logic                  rsp_bad_ff, rsp_bad_in;
   logic [MAX_PINS-1:0]   rsp_drive_value_ff;
   logic [MAX_PINS-1:0]   rsp_drive_enable_ff;
   logic [MAX_PINS-1:0]   rsp_open_drain_ff;

   logic [MAX_PINS-1:0]   act;
   logic [MAX_PINS-1:0]   enabled_ff;
   logic [MAX_PINS-1:0]   enabled_in;
   logic [MAX_PINS-1:0]   lv;
   logic [63:0]           sh;

   // Apply a direct/set/clear write to one vector
   function automatic logic [MAX_PINS-1:0] apply_write(
      input logic [MAX_PINS-1:0] vec,
      input gpioc_pkg::kind_type kind,
      input logic                hi,
      input logic [63:0]         shv,
      input logic [MAX_PINS-1:0] mask
   );
      logic [63:0] v;
      v = 64'(vec);
      unique case (kind)
         gpioc_pkg::KIND_DIRECT: begin
            v = (v & (hi ? 64'h0000_0000_ffff_ffff : 64'hffff_ffff_0000_0000)) | shv;
         end
         gpioc_pkg::KIND_SET:    v = v | shv;
         gpioc_pkg::KIND_CLEAR:  v = v & ~shv;
         default:                v = v;
      endcase
      return v[MAX_PINS-1:0] & mask;
   endfunction

   // Pick the low or high 32-bit group of a vector
   function automatic logic [31:0] group_word(input logic [MAX_PINS-1:0] vec,
                                              input logic hi);
      logic [63:0] v;
      v = 64'(vec);
      return hi ? v[63:32] : v[31:0];
   endfunction

   // Address decode of the incoming item
   gpioc_decode #(
      .MAX_PINS (MAX_PINS)
   ) u_decode (
      .variant (variant_ff),
      .address (req_address),
      .dec     (dec),
      .pin_idx (pin_idx)
   );

   // Pin word memory: read at accept, write back in the execute cycle
   gpioc_ram #(
      .WIDTH (32),
      .DEPTH (MAX_PINS)
   ) u_pin_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data (wdata_ff),
      .rd_en   (accept),
      .rd_addr (pin_idx),
      .rd_data (ram_rdata)
   );

   // Next state
   always_comb begin
      unique case (state_ff)
         gpioc_pkg::ST_IDLE: state_in = accept ? gpioc_pkg::ST_EXEC : gpioc_pkg::ST_IDLE;
         gpioc_pkg::ST_EXEC: state_in = gpioc_pkg::ST_IDLE;
         default:            state_in = gpioc_pkg::ST_IDLE;
      endcase
   end

   // Handshake outputs
   always_comb begin
      busy      = (state_ff == gpioc_pkg::ST_EXEC);
      accept    = start && !busy;
      csr_ready = !busy && !start;
   end

   // Masks shared by the execute logic
   always_comb begin
      act        = variant_ff ? {MAX_PINS{1'b1}} : ACT0;
      enabled_ff = variant_ff ? en_lo_ff : (en_lo_ff | en_hi_ff);
      lv         = levels_ff & act;
      sh         = dec_ff.hi ? {wdata_ff, 32'h0} : {32'h0, wdata_ff};
   end

   // Execute: read, modify and write back
   always_comb begin
      out_in           = out_ff;
      ena_in           = ena_ff;
      sts_in           = sts_ff;
      last_in          = last_ff;
      od_in            = od_ff;
      en_lo_in         = en_lo_ff;
      en_hi_in         = en_hi_ff;
      valid_in         = valid_ff;
      type_in          = type_ff;
      ram_we           = 1'b0;
      rsp_read_data_in = 32'h0;
      rsp_bad_in       = 1'b0;
      if (state_ff == gpioc_pkg::ST_EXEC) begin
         case (op_ff)
            gpioc_pkg::OP_READ: begin
               unique case (dec_ff.target)
                  gpioc_pkg::TGT_OUT: begin
                     if (dec_ff.kind == gpioc_pkg::KIND_DIRECT) begin
                        rsp_read_data_in = group_word(out_ff & act, dec_ff.hi);
                     end
                  end
                  gpioc_pkg::TGT_ENA: begin
                     if (dec_ff.kind == gpioc_pkg::KIND_DIRECT) begin
                        rsp_read_data_in = group_word(ena_ff & act, dec_ff.hi);
                     end
                  end
                  gpioc_pkg::TGT_STS: begin
                     if (dec_ff.kind == gpioc_pkg::KIND_DIRECT) begin
                        rsp_read_data_in = group_word(sts_ff & act, dec_ff.hi);
                     end
                  end
                  gpioc_pkg::TGT_INPUT: rsp_read_data_in = group_word(last_ff & act, dec_ff.hi);
                  gpioc_pkg::TGT_INT: begin
                     rsp_read_data_in = group_word(sts_ff & enabled_ff & act, dec_ff.hi);
                  end
                  gpioc_pkg::TGT_PIN: rsp_read_data_in = valid_ff[idx_ff] ? ram_rdata : 32'h0;
                  default:            rsp_bad_in = 1'b1;
               endcase
            end
            gpioc_pkg::OP_WRITE: begin
               unique case (dec_ff.target)
                  gpioc_pkg::TGT_OUT: out_in = apply_write(out_ff, dec_ff.kind, dec_ff.hi, sh, act);
                  gpioc_pkg::TGT_ENA: ena_in = apply_write(ena_ff, dec_ff.kind, dec_ff.hi, sh, act);
                  gpioc_pkg::TGT_STS: sts_in = apply_write(sts_ff, dec_ff.kind, dec_ff.hi, sh, act);
                  gpioc_pkg::TGT_INPUT, gpioc_pkg::TGT_INT: begin
                     ram_we = 1'b0;
                  end
                  gpioc_pkg::TGT_PIN: begin
                     ram_we            = 1'b1;
                     valid_in[idx_ff]  = 1'b1;
                     od_in[idx_ff]     = wdata_ff[gpioc_pkg::OD_POS];
                     en_lo_in[idx_ff]  = wdata_ff[gpioc_pkg::EN_LO_POS];
                     en_hi_in[idx_ff]  = wdata_ff[gpioc_pkg::EN_HI_POS];
                     type_in[idx_ff]   = wdata_ff[gpioc_pkg::TYPE_LSB +: 3];
                  end
                  default: rsp_bad_in = 1'b1;
               endcase
            end
            gpioc_pkg::OP_SAMPLE: begin
               // Record edges and levels per pin
               for (int i = 0; i < MAX_PINS; i++) begin
                  unique case (type_ff[i])
                     gpioc_pkg::TYPE_RISE: sts_in[i] = sts_ff[i] | (lv[i] & !last_ff[i]);
                     gpioc_pkg::TYPE_FALL: sts_in[i] = sts_ff[i] | (!lv[i] & last_ff[i]);
                     gpioc_pkg::TYPE_ANY:  sts_in[i] = sts_ff[i] | (lv[i] ^ last_ff[i]);
                     gpioc_pkg::TYPE_LOW:  sts_in[i] = sts_ff[i] | !lv[i];
                     gpioc_pkg::TYPE_HIGH: sts_in[i] = sts_ff[i] | lv[i];
                     default:              sts_in[i] = sts_ff[i];
                  endcase
               end
               sts_in  = sts_in & act;
               last_in = lv;
            end
            default: begin
               ram_we = 1'b0;
            end
         endcase
      end
      enabled_in = variant_ff ? en_lo_in : (en_lo_in | en_hi_in);
      rsp_irq_in = |(sts_in & enabled_in & act);
   end

   // Control and pin state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gpioc_pkg::ST_IDLE;
         variant_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         out_ff       <= '0;
         ena_ff       <= '0;
         sts_ff       <= '0;
         last_ff      <= '0;
         od_ff        <= '0;
         en_lo_ff     <= '0;
         en_hi_ff     <= '0;
         valid_ff     <= '0;
         for (int i = 0; i < MAX_PINS; i++) begin
            type_ff[i] <= 3'd0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == gpioc_pkg::ST_EXEC);
         if (csr_valid && csr_ready) begin
            variant_ff <= csr_chip_variant;
         end
         out_ff   <= out_in;
         ena_ff   <= ena_in;
         sts_ff   <= sts_in;
         last_ff  <= last_in;
         od_ff    <= od_in;
         en_lo_ff <= en_lo_in;
         en_hi_ff <= en_hi_in;
         valid_ff <= valid_in;
         type_ff  <= type_in;
      end
   end

   // Hold the accepted item
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= gpioc_pkg::op_type'(req_operation);
         wdata_ff  <= req_write_data;
         levels_ff <= req_pin_levels;
         dec_ff    <= dec;
         idx_ff    <= pin_idx;
      end
   end

   // Capture the result at the end of execute
   always_ff @(posedge clock) begin
      if (state_ff == gpioc_pkg::ST_EXEC) begin
         rsp_read_data_ff    <= rsp_read_data_in;
         rsp_irq_ff          <= rsp_irq_in;
         rsp_bad_ff          <= rsp_bad_in;
         rsp_drive_value_ff  <= out_in & act;
         rsp_drive_enable_ff <= ena_in & act;
         rsp_open_drain_ff   <= od_in & act;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_read_data_ff;
   assign rsp_irq          = rsp_irq_ff;
   assign rsp_bad_address  = rsp_bad_ff;
   assign rsp_drive_value  = rsp_drive_value_ff;
   assign rsp_drive_enable = rsp_drive_enable_ff;
   assign rsp_open_drain   = rsp_open_drain_ff;

   // Every accepted item yields its result once its execute state has passed
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid_ff)
      else $error("accepted item produced no result");

   // A result only follows an execute cycle
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == gpioc_pkg::ST_EXEC))
      else $error("result without execute cycle");

   // Writes and samples return no read data
   a_no_data_on_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (op_ff != gpioc_pkg::OP_READ)) |-> (rsp_read_data_ff == 32'h0))
      else $error("read data on non-read item");

   // Irq matches the stored status and enables
   a_irq_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_irq_ff == (|(sts_ff & enabled_ff & act))))
      else $error("irq disagrees with status");

   // Inactive pins of the small variant drive nothing
   a_inactive_pins: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !variant_ff) |->
         (((rsp_drive_value_ff | rsp_drive_enable_ff | rsp_open_drain_ff) & ~ACT0) == '0))
      else $error("inactive pin driven");

endmodule
